@@ hw/rtl/tppl_pkg.sv @@
// Shared types, widths, codes and coefficient tables of the thermistor linearizer.
package tppl_pkg;

    localparam int CODE_W        = 16;
    localparam int VPC_W         = 16;
    localparam int TEMP_W        = 16;
    localparam int V_W           = 18;
    localparam int VB_W          = V_W + 1;
    localparam int ACC_W         = 36;
    localparam int PROD_W        = ACC_W + VB_W;
    localparam int COEF_W        = 31;
    localparam int FRAC_BITS     = 16;
    localparam int OUT_SHIFT     = 8;
    localparam int NUM_TERMS     = 5;
    localparam int NUM_SEGS      = 4;
    localparam int SEG_W         = 2;
    localparam int STEP_W        = 3;
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int TEMP_MAX      = 32767;
    localparam int TEMP_MIN      = -32768;

    localparam logic [VPC_W-1:0] VPC_RESET = 16'd1049;

    localparam logic [V_W-1:0] VOLT_MAX = 18'h3FFFF;
    localparam logic [V_W-1:0] BREAK1   = 18'd51156;
    localparam logic [V_W-1:0] BREAK2   = 18'd103461;
    localparam logic [V_W-1:0] BREAK3   = 18'd128716;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_SELECT = 3'd3;
    localparam logic [2:0] OP_MUL    = 3'd4;
    localparam logic [2:0] OP_ADD    = 3'd5;
    localparam logic [2:0] OP_FINAL  = 3'd6;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TERMS - 1);

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [STEP_W-1:0] step;
    } ctrl_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     held;
        logic                     sat;
    } res_t;

    // Segment polynomial coefficients in Q.16, highest power first.
    localparam coef_t SEG_COEF [NUM_SEGS][NUM_TERMS] = '{
        '{-31'sd4594074, 31'sd12622234, -31'sd13775667, 31'sd10092544, -31'sd3781427},
        '{31'sd595853, -31'sd1660682, 31'sd1602355, 31'sd2338980, -31'sd2232812},
        '{31'sd31214797, -31'sd205848576, 31'sd513409024, -31'sd568918016,
          31'sd237240320},
        '{31'sd0, 31'sd0, 31'sd56308531, -31'sd210960384, 31'sd202440704}
    };

endpackage

@@ hw/rtl/tppl_if.sv @@
// Valid/ready channel interfaces for samples, results and the configuration write.
interface tppl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tppl_pkg::CODE_W-1:0]   adc_code;
    logic                                 sensor_channel;

    modport source (output valid, output adc_code, output sensor_channel, input ready);
    modport sink (input valid, input adc_code, input sensor_channel, output ready);
endinterface

interface tppl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tppl_pkg::TEMP_W-1:0]   temperature_q8_8;
    logic                                 held_previous;
    logic                                 saturated;

    modport source (output valid, output temperature_q8_8, output held_previous,
                    output saturated, input ready);
    modport sink (input valid, input temperature_q8_8, input held_previous,
                  input saturated, output ready);
endinterface

interface tppl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tppl_pkg::VPC_W-1:0]         data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tppl_seq.sv @@
// Sequencer that steps the shared multiplier through scaling and Horner evaluation.
module tppl_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  held,
    input  logic                  out_free,
    output logic                  in_ready,
    output tppl_pkg::ctrl_t       ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_SELECT = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [tppl_pkg::STEP_W-1:0]   step_reg;
    logic [tppl_pkg::STEP_W-1:0]   step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl.op    = tppl_pkg::OP_NONE;
        ctrl.step  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.op    = tppl_pkg::OP_LOAD;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                ctrl.op    = tppl_pkg::OP_SCALE;
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                ctrl.op    = tppl_pkg::OP_SELECT;
                step_next  = tppl_pkg::STEP_W'(1);
                state_next = held ? S_FINAL : S_MUL;
            end
            S_MUL:
            begin
                ctrl.op    = tppl_pkg::OP_MUL;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ctrl.op = tppl_pkg::OP_ADD;
                if (step_reg == tppl_pkg::LAST_STEP)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    step_next  = step_reg + tppl_pkg::STEP_W'(1);
                    state_next = S_MUL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    ctrl.op    = tppl_pkg::OP_FINAL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> (step_reg >= tppl_pkg::STEP_W'(1)
                                  && step_reg <= tppl_pkg::LAST_STEP))
        else $error("Horner step counter out of range");

    a_add_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> ($past(state_reg) == S_MUL))
        else $error("Accumulate step without a preceding multiply");

    a_held_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELECT && held) |=> (state_reg == S_FINAL))
        else $error("Held sample did not skip the polynomial");

endmodule

@@ hw/rtl/tppl_datapath.sv @@
// Shared multiplier datapath: voltage scaling, segment choice, Horner steps and saturation.
module tppl_datapath
#(
    parameter int NUM_CHANNELS = tppl_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tppl_pkg::ctrl_t                    ctrl,
    input  logic signed [tppl_pkg::CODE_W-1:0] in_code,
    input  logic                               in_channel,
    input  logic [tppl_pkg::VPC_W-1:0]         vpc,
    output logic                               held,
    output tppl_pkg::res_t                     res
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic signed [tppl_pkg::CODE_W-1:0]  code_reg;
    logic [CH_W-1:0]                     ch_reg;
    logic signed [tppl_pkg::PROD_W-1:0]  prod_reg;
    logic [tppl_pkg::V_W-1:0]            v_reg;
    logic [tppl_pkg::SEG_W-1:0]          seg_reg;
    logic signed [tppl_pkg::ACC_W-1:0]   acc_reg;
    logic                                held_reg;
    logic signed [tppl_pkg::TEMP_W-1:0]  last_reg [NUM_CHANNELS];

    logic signed [tppl_pkg::ACC_W-1:0]   mul_a;
    logic signed [tppl_pkg::VB_W-1:0]    mul_b;
    logic signed [tppl_pkg::PROD_W-1:0]  prod_next;
    logic [tppl_pkg::V_W-1:0]            v_sel;
    logic [tppl_pkg::SEG_W-1:0]          seg_sel;
    logic signed [tppl_pkg::PROD_W-1:0]  prod_rnd;
    logic signed [tppl_pkg::PROD_W-1:0]  prod_shr;
    logic signed [tppl_pkg::ACC_W-1:0]   acc_next;
    logic signed [tppl_pkg::ACC_W-1:0]   acc_rnd;
    logic signed [tppl_pkg::ACC_W-1:0]   t_full;
    logic                                t_hi;
    logic                                t_lo;

    // The one multiplier serves both the code scaling and every Horner step.
    always_comb
    begin
        if (ctrl.op == tppl_pkg::OP_SCALE)
        begin
            mul_a = tppl_pkg::ACC_W'(code_reg);
            mul_b = signed'({3'b000, vpc});
        end
        else
        begin
            mul_a = acc_reg;
            mul_b = signed'({1'b0, v_reg});
        end
    end

    assign prod_next = tppl_pkg::PROD_W'(mul_a) * tppl_pkg::PROD_W'(mul_b);

    assign held = prod_reg[tppl_pkg::PROD_W-1];

    always_comb
    begin
        if (prod_reg[tppl_pkg::PROD_W-2:tppl_pkg::V_W+tppl_pkg::OUT_SHIFT] != '0)
        begin
            v_sel = tppl_pkg::VOLT_MAX;
        end
        else
        begin
            v_sel = prod_reg[tppl_pkg::V_W+tppl_pkg::OUT_SHIFT-1:tppl_pkg::OUT_SHIFT];
        end
        if (v_sel <= tppl_pkg::BREAK1)
        begin
            seg_sel = 2'd0;
        end
        else if (v_sel <= tppl_pkg::BREAK2)
        begin
            seg_sel = 2'd1;
        end
        else if (v_sel <= tppl_pkg::BREAK3)
        begin
            seg_sel = 2'd2;
        end
        else
        begin
            seg_sel = 2'd3;
        end
    end

    assign prod_rnd = prod_reg
                      + (tppl_pkg::PROD_W'(1) <<< (tppl_pkg::FRAC_BITS - 1));
    assign prod_shr = prod_rnd >>> tppl_pkg::FRAC_BITS;
    assign acc_next = prod_shr[tppl_pkg::ACC_W-1:0]
                      + tppl_pkg::ACC_W'(tppl_pkg::SEG_COEF[seg_reg][ctrl.step]);

    assign acc_rnd = acc_reg + (tppl_pkg::ACC_W'(1) <<< (tppl_pkg::OUT_SHIFT - 1));
    assign t_full  = acc_rnd >>> tppl_pkg::OUT_SHIFT;
    assign t_hi    = (t_full > tppl_pkg::ACC_W'(tppl_pkg::TEMP_MAX));
    assign t_lo    = (t_full < tppl_pkg::ACC_W'(tppl_pkg::TEMP_MIN));

    always_comb
    begin
        res.held = held_reg;
        res.sat  = 1'b0;
        if (held_reg)
        begin
            res.temperature = last_reg[ch_reg];
        end
        else if (t_hi)
        begin
            res.temperature = tppl_pkg::TEMP_W'(tppl_pkg::TEMP_MAX);
            res.sat         = 1'b1;
        end
        else if (t_lo)
        begin
            res.temperature = tppl_pkg::TEMP_W'(tppl_pkg::TEMP_MIN);
            res.sat         = 1'b1;
        end
        else
        begin
            res.temperature = t_full[tppl_pkg::TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            tppl_pkg::OP_LOAD:
            begin
                code_reg <= in_code;
                ch_reg   <= (NUM_CHANNELS == 1) ? '0 : CH_W'(in_channel);
            end
            tppl_pkg::OP_SCALE, tppl_pkg::OP_MUL:
            begin
                prod_reg <= prod_next;
            end
            tppl_pkg::OP_SELECT:
            begin
                held_reg <= held;
                v_reg    <= v_sel;
                seg_reg  <= seg_sel;
                acc_reg  <= tppl_pkg::ACC_W'(tppl_pkg::SEG_COEF[seg_sel][0]);
            end
            tppl_pkg::OP_ADD:
            begin
                acc_reg <= acc_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (ctrl.op == tppl_pkg::OP_FINAL && !held_reg)
        begin
            last_reg[ch_reg] <= res.temperature;
        end
    end

endmodule

@@ hw/rtl/thermistor_piecewise_poly_linearizer.sv @@
// Top level of the thermistor linearizer: channels, configuration register and result register.
//
// The sample channel carries a signed 16-bit converter code and a sensor channel
// number; the result channel returns the temperature in signed Q8.8 degrees Celsius
// with a held flag and a saturation flag. The cfg channel writes the volts-per-code
// factor in Q0.24 and is always ready; write it only while no sample is in flight.
// Each sample is scaled to volts, matched to one of four polynomial segments and
// evaluated by Horner steps on a single shared multiplier, a multiply step and an
// accumulate step for each coefficient after the first. The sequencer runs LOAD,
// SCALE, SELECT, the MUL/ADD pairs and FINAL, which loads the result register; a
// negative voltage goes from SELECT straight to FINAL and returns the channel's last
// value. A new sample is taken only while the sequencer is idle after FINAL.
// The result register holds its transfer until the receiver takes it; a finished
// sample waits in the sequencer while the register is full, and a new sample can
// be taken while the last result still waits. Reset restores the factor to 1049,
// clears every channel's last temperature to zero and empties the result register.
module thermistor_piecewise_poly_linearizer
#(
    parameter int NUM_CHANNELS = tppl_pkg::NUM_CHANNELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    tppl_in_if.sink          sample,
    tppl_out_if.source       result,
    tppl_cfg_if.sink         cfg
);

    logic [tppl_pkg::VPC_W-1:0]          vpc_reg;
    logic                                out_valid_reg;
    logic signed [tppl_pkg::TEMP_W-1:0]  temp_reg;
    logic                                held_out_reg;
    logic                                sat_reg;

    logic             in_fire;
    logic             in_ready;
    logic             out_free;
    logic             held;
    tppl_pkg::ctrl_t  ctrl;
    tppl_pkg::res_t   res;

    assign sample.ready = in_ready;
    assign in_fire      = sample.valid && in_ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    tppl_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .held     (held),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    tppl_datapath
    #(
        .NUM_CHANNELS (NUM_CHANNELS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_code    (sample.adc_code),
        .in_channel (sample.sensor_channel),
        .vpc        (vpc_reg),
        .held       (held),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpc_reg <= tppl_pkg::VPC_RESET;
        end
        else if (cfg.valid)
        begin
            vpc_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.op == tppl_pkg::OP_FINAL)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == tppl_pkg::OP_FINAL)
        begin
            temp_reg     <= res.temperature;
            held_out_reg <= res.held;
            sat_reg      <= res.sat;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.temperature_q8_8 = temp_reg;
    assign result.held_previous    = held_out_reg;
    assign result.saturated        = sat_reg;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !sample.ready)
        else $error("Sample channel ready again right after a transfer");

    a_final_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == tppl_pkg::OP_FINAL) |-> out_free)
        else $error("Result loaded over an untaken result");

    a_held_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.held_previous) |-> !result.saturated)
        else $error("Held result flagged as saturated");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated)
        |-> (result.temperature_q8_8 == tppl_pkg::TEMP_W'(tppl_pkg::TEMP_MAX)
             || result.temperature_q8_8 == tppl_pkg::TEMP_W'(tppl_pkg::TEMP_MIN)))
        else $error("Saturated result not at a range limit");

endmodule

@@ bench/tb_thermistor_piecewise_poly_linearizer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the thermistor linearizer: a directed table, then random samples.
module tb_thermistor_piecewise_poly_linearizer;

    localparam int          LIMIT_CYCLES  = 300000;
    localparam int          DRAIN_CYCLES  = 24;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 92;
    localparam int          CALM_PHASE    = 3;
    localparam longint      V_CLAMP_Q16   = 64'h3FFFF;
    localparam longint      V_BP1_Q16     = 51156;
    localparam longint      V_BP2_Q16     = 103461;
    localparam longint      V_BP3_Q16     = 128716;
    localparam longint      T_MAX_Q8      = 32767;
    localparam longint      T_MIN_Q8      = -32768;
    localparam logic [15:0] VPC_DEFAULT   = 16'd1049;
    localparam logic [15:0] VPC_MAX       = 16'd65535;
    localparam logic [15:0] VPC_MIN       = 16'd1;

    localparam longint SEG_COEF_Q16 [4][5] = '{
        '{-64'sd4594074, 64'sd12622234, -64'sd13775667, 64'sd10092544, -64'sd3781427},
        '{64'sd595853, -64'sd1660682, 64'sd1602355, 64'sd2338980, -64'sd2232812},
        '{64'sd31214797, -64'sd205848576, 64'sd513409024, -64'sd568918016,
          64'sd237240320},
        '{64'sd0, 64'sd0, 64'sd56308531, -64'sd210960384, 64'sd202440704}
    };

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [15:0]    value;
        logic           chan;
        logic           typed;
        tppl_pkg::res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tppl_in_if  sample_if ();
    tppl_out_if result_if ();
    tppl_cfg_if cfg_if ();

    thermistor_piecewise_poly_linearizer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    logic                    typed_pending = 1'b0;
    tppl_pkg::res_t          typed_want = '0;
    logic                    calm = 1'b0;
    int                      burst_left = 0;
    int                      ready_left = 0;
    int                      mismatches = 0;
    int                      cycles = 0;
    logic [15:0]             vpc_model = VPC_DEFAULT;
    logic signed [15:0]      last_temp_model [2] = '{16'sd0, 16'sd0};
    tppl_pkg::res_t          pending_temps [$];

    always #5 clk = ~clk;

    function automatic longint round_half_up(input longint x, input int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic tppl_pkg::res_t predict_temperature(input logic signed [15:0] code,
                                                           input logic chan);
        longint         prod;
        longint         volts;
        longint         acc;
        longint         t;
        int             seg;
        tppl_pkg::res_t r;
        prod = longint'(code) * longint'(vpc_model);
        r.sat = 1'b0;
        if (prod < 0)
        begin
            r.temperature = last_temp_model[chan];
            r.held = 1'b1;
            return r;
        end
        volts = prod >>> 8;
        if (volts > V_CLAMP_Q16)
            volts = V_CLAMP_Q16;
        if (volts <= V_BP1_Q16)
            seg = 0;
        else if (volts <= V_BP2_Q16)
            seg = 1;
        else if (volts <= V_BP3_Q16)
            seg = 2;
        else
            seg = 3;
        acc = SEG_COEF_Q16[seg][0];
        for (int k = 1; k < 5; k++)
            acc = round_half_up(acc * volts, 16) + SEG_COEF_Q16[seg][k];
        t = round_half_up(acc, 8);
        if (t > T_MAX_Q8)
        begin
            t = T_MAX_Q8;
            r.sat = 1'b1;
        end
        else if (t < T_MIN_Q8)
        begin
            t = T_MIN_Q8;
            r.sat = 1'b1;
        end
        r.temperature = 16'(t);
        r.held = 1'b0;
        last_temp_model[chan] = r.temperature;
        return r;
    endfunction

    // Most codes aim at a voltage near a breakpoint, near zero or spread over the range.
    function automatic logic [15:0] pick_code(input logic [15:0] vpc);
        longint target;
        longint code;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 16'($urandom);
        if (pick < 27)
            return 16'(-64'sd1 - longint'($urandom_range(0, 300)));
        case ($urandom_range(0, 4))
            0: target = V_BP1_Q16 + longint'($urandom_range(0, 400)) - 200;
            1: target = V_BP2_Q16 + longint'($urandom_range(0, 400)) - 200;
            2: target = V_BP3_Q16 + longint'($urandom_range(0, 400)) - 200;
            3: target = longint'($urandom_range(0, 300));
            default: target = longint'($urandom_range(0, 262143));
        endcase
        code = target * 256 / longint'(vpc) + longint'($urandom_range(0, 4)) - 2;
        if (code < 0)
            code = 0;
        if (code > 32767)
            code = 32767;
        return 16'(code);
    endfunction

    task automatic send_item(input logic [15:0] code, input logic chan, input logic typed,
                             input tppl_pkg::res_t want);
        int gap;
        if (burst_left == 0)
        begin
            if (!calm)
            begin
                gap = $urandom_range(1, 10);
                sample_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        sample_if.valid          <= 1'b1;
        sample_if.adc_code       <= code;
        sample_if.sensor_channel <= chan;
        typed_pending            <= typed;
        typed_want               <= want;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    // The factor is written only once every result of the previous setting is back.
    task automatic write_vpc(input logic [15:0] value, input logic calm_next);
        sample_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending_temps.size() != 0)
            @(negedge clk);
        calm = calm_next;
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_sink
        logic next_ready;
        next_ready = result_if.ready;
        if (calm)
            next_ready = 1'b1;
        else if (ready_left == 0)
        begin
            next_ready = ~result_if.ready;
            ready_left = next_ready ? $urandom_range(1, 12) : $urandom_range(1, 8);
        end
        else
            ready_left--;
        result_if.ready <= next_ready;
    end

    always @(posedge clk)
    begin : scoreboard
        tppl_pkg::res_t want;
        tppl_pkg::res_t pred;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (pending_temps.size() == 0)
                begin
                    $error("result transfer with nothing expected: temperature_q8_8=%0d",
                           result_if.temperature_q8_8);
                    mismatches++;
                end
                else
                begin
                    want = pending_temps.pop_front();
                    if (result_if.temperature_q8_8 !== want.temperature)
                    begin
                        $error("temperature_q8_8: expected %0d, got %0d",
                               want.temperature, result_if.temperature_q8_8);
                        mismatches++;
                    end
                    if (result_if.held_previous !== want.held)
                    begin
                        $error("held_previous: expected %0b, got %0b",
                               want.held, result_if.held_previous);
                        mismatches++;
                    end
                    if (result_if.saturated !== want.sat)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.sat, result_if.saturated);
                        mismatches++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                vpc_model = cfg_if.data;
            if (sample_if.valid && sample_if.ready)
            begin
                pred = predict_temperature(sample_if.adc_code, sample_if.sensor_channel);
                pending_temps.push_back(typed_pending ? typed_want : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t   rows [$];
        logic [15:0] vpc;
        sample_if.valid          = 1'b0;
        sample_if.adc_code       = '0;
        sample_if.sensor_channel = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.data              = '0;
        result_if.ready          = 1'b0;

        // After reset both channels hold zero.
        rows.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, '{16'sd0, 1'b1, 1'b0}});
        rows.push_back('{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}});
        rows.push_back('{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'hFFFB, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'h7FFF, 1'b1, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'h0001, 1'b1, 1'b0, '0});
        // Factors chosen so that the voltage lands exactly on each breakpoint.
        rows.push_back('{ROW_CFG, 16'd25578, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd511, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd512, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd513, 1'b1, 1'b0, '0});
        rows.push_back('{ROW_CFG, 16'd34487, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd768, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd769, 1'b1, 1'b0, '0});
        rows.push_back('{ROW_CFG, 16'd64358, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd512, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'd513, 1'b1, 1'b0, '0});
        rows.push_back('{ROW_CFG, VPC_MAX, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b1, '{16'sh7FFF, 1'b0, 1'b1}});
        rows.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}});
        rows.push_back('{ROW_SAMPLE, 16'h4000, 1'b1, 1'b1, '{16'sh7FFF, 1'b0, 1'b1}});
        rows.push_back('{ROW_CFG, VPC_MIN, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b0, '0});
        rows.push_back('{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}});
        rows.push_back('{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_vpc(rows[i].value, 1'b0);
            else
                send_item(rows[i].value, rows[i].chan, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: vpc = VPC_DEFAULT;
                1: vpc = VPC_MAX;
                2: vpc = VPC_MIN;
                default: vpc = 16'($urandom_range(1, 65535));
            endcase
            write_vpc(vpc, p == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_code(vpc), 1'($urandom), 1'b0, '0);
        end

        sample_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_temps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tppl_pkg.sv
hw/rtl/tppl_if.sv
hw/rtl/tppl_seq.sv
hw/rtl/tppl_datapath.sv
hw/rtl/thermistor_piecewise_poly_linearizer.sv
bench/tb_thermistor_piecewise_poly_linearizer.sv
